// ----- rtl/core/psp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared constants and types of the PAT section parser: table size, field
// widths, request and result codes and the result record.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W     = 29;
	localparam int POS_W       = 12;
	localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		RK_HEADER = 2'd0,
		RK_ENTRY  = 2'd1,
		RK_LOOKUP = 2'd2
	} psp_kind_t;

	typedef enum logic {
		LK_IDLE = 1'b0,
		LK_SCAN = 1'b1
	} psp_lk_state_t;

	typedef struct packed {
		psp_kind_t   kind;
		logic [7:0]  tbl_id;
		logic        syntax_indicator;
		logic [11:0] sect_len;
		logic [15:0] stream_id;
		logic [4:0]  version;
		logic        current_next;
		logic [7:0]  section_index;
		logic [7:0]  last_section_index;
		logic [9:0]  entry_total;
		logic [15:0] prog_num;
		logic [12:0] pid;
	} psp_result_t;

endpackage

// ----- rtl/core/psp_entry_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_entry_ram
// Entry table: one write port and one read port with registered read data.
// Each word holds the program number above the 13-bit PID.
// ----------------------------------------------------------------------------
module psp_entry_ram import psp_pkg::*; (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/pat_section_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_section_parser_core
// Parses PAT section bytes into header and entry results, stores the entries
// of the current section and answers PMT PID lookups by program number.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | request   | in_valid / in_stall  | opcode, data_byte, first_byte, svc_id
//  out     | result    | out_valid / out_stall| result_kind ... pid
//
//  A byte item can be taken every cycle while in_stall is low.
//  A lookup on an empty table is answered without a RAM walk. Otherwise it walks the
//  entry RAM one word a cycle and holds in_stall until the walk has answered.
//  Results go to an output register backed by one skid register, so input is
//  stalled only while the skid register is occupied or a lookup runs.
//  Reset clears all control state; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module pat_section_parser_core import psp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic [15:0] svc_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  tbl_id,
	output logic        syntax_indicator,
	output logic [11:0] sect_len,
	output logic [15:0] stream_id,
	output logic [4:0]  version,
	output logic        current_next,
	output logic [7:0]  section_index,
	output logic [7:0]  last_section_index,
	output logic [9:0]  entry_total,
	output logic [15:0] prog_num,
	output logic [12:0] pid
);

	logic [POS_W-1:0]   pos_q;
	logic [55:0]        hdr_q;
	logic [9:0]         exp_q;
	logic [23:0]        part_q;
	logic [CNT_W-1:0]   stored_q;

	psp_lk_state_t      state_q, state_d;
	logic               issue_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               chk_s1;
	logic               last_s1;
	logic [15:0]        sid_q;

	psp_result_t        out_q, skid_q, new_res;
	logic               out_valid_q, skid_valid_q, new_valid;

	logic               in_fire, byte_fire, lk_fire, lk_start;
	logic [POS_W-1:0]   pos_eff, pos_d, rel;
	logic [63:0]        hdr_full;
	logic [11:0]        len;
	logic [9:0]         exp_calc, idx;
	logic [1:0]         sub;
	logic               in_hdr, hdr_done, entry_live, entry_done;
	logic [31:0]        word;
	logic [CNT_W-1:0]   stored_base;
	logic               wr_en;
	logic [ENTRY_W-1:0] rd_data;
	logic [15:0]        rd_prog;
	logic               last_addr, match, lk_done, out_open;

	assign in_stall  = (state_q == LK_SCAN) | skid_valid_q;
	assign in_fire   = in_valid & ~in_stall;
	assign byte_fire = in_fire & (opcode == OP_BYTE);
	assign lk_fire   = in_fire & (opcode == OP_LOOKUP);
	assign lk_start  = lk_fire & (stored_q != '0);

	// Byte decode: a first byte restarts the section at position 0.
	always_comb begin
		pos_eff     = first_byte ? '0 : pos_q;
		pos_d       = (pos_eff < POS_MAX) ? pos_eff + POS_W'(1) : pos_eff;
		hdr_full    = {hdr_q, data_byte};
		len         = hdr_full[51:40];
		exp_calc    = (len < 12'd9) ? '0 : 10'((len - 12'd9) >> 2);
		rel         = pos_eff - POS_W'(8);
		idx         = rel[11:2];
		sub         = rel[1:0];
		in_hdr      = pos_eff < POS_W'(8);
		hdr_done    = byte_fire & (pos_eff == POS_W'(7));
		entry_live  = ~in_hdr & (idx < exp_q);
		entry_done  = byte_fire & entry_live & (sub == 2'd3);
		word        = {part_q, data_byte};
		stored_base = first_byte ? '0 : stored_q;
		wr_en       = entry_done & (stored_base < CNT_W'(MAX_ENTRIES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			exp_q    <= '0;
			stored_q <= '0;
		end else if (byte_fire) begin
			pos_q    <= pos_d;
			stored_q <= stored_base + CNT_W'(wr_en);
			if (hdr_done) begin
				exp_q <= exp_calc;
			end else if (first_byte) begin
				exp_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && in_hdr) begin
			hdr_q <= {hdr_q[47:0], data_byte};
		end
		if (byte_fire && entry_live && sub != 2'd3) begin
			part_q <= {part_q[15:0], data_byte};
		end
		if (lk_start) begin
			sid_q <= svc_id;
		end
	end

	psp_entry_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (stored_base[ADDR_W-1:0]),
		.wr_data ({word[31:16], word[12:0]}),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// Lookup walk: one address issued per cycle, compared in the next cycle.
	assign rd_prog   = rd_data[28:13];
	assign last_addr = (CNT_W'(addr_q) + CNT_W'(1)) == stored_q;
	assign match     = chk_s1 & (rd_prog != 16'd0) & (rd_prog == sid_q);
	assign lk_done   = chk_s1 & (match | last_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LK_IDLE: begin
				if (lk_start) begin
					state_d = LK_SCAN;
				end
			end
			LK_SCAN: begin
				if (lk_done) begin
					state_d = LK_IDLE;
				end
			end
			default: state_d = LK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LK_IDLE;
			issue_q <= 1'b0;
			addr_q  <= '0;
			chk_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= issue_q & ~lk_done;
			last_s1 <= last_addr;
			if (lk_start) begin
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else if (lk_done) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				addr_q  <= addr_q + ADDR_W'(1);
				issue_q <= ~last_addr;
			end
		end
	end

	// Result builder: the sources never fire in the same cycle.
	always_comb begin
		new_res   = '0;
		new_valid = 1'b0;
		priority if (hdr_done) begin
			new_valid                  = 1'b1;
			new_res.kind               = RK_HEADER;
			new_res.tbl_id             = hdr_full[63:56];
			new_res.syntax_indicator   = hdr_full[55];
			new_res.sect_len           = len;
			new_res.stream_id          = hdr_full[39:24];
			new_res.version            = hdr_full[21:17];
			new_res.current_next       = hdr_full[16];
			new_res.section_index      = hdr_full[15:8];
			new_res.last_section_index = hdr_full[7:0];
			new_res.entry_total        = exp_calc;
		end else if (entry_done) begin
			new_valid        = 1'b1;
			new_res.kind     = RK_ENTRY;
			new_res.prog_num = word[31:16];
			new_res.pid      = word[12:0];
		end else if (lk_fire && !lk_start) begin
			new_valid        = 1'b1;
			new_res.kind     = RK_LOOKUP;
			new_res.prog_num = svc_id;
		end else if (lk_done) begin
			new_valid        = 1'b1;
			new_res.kind     = RK_LOOKUP;
			new_res.prog_num = sid_q;
			new_res.pid      = match ? rd_data[12:0] : 13'd0;
		end else begin
			new_valid = 1'b0;
		end
	end

	assign out_open = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q  <= skid_valid_q | new_valid;
			skid_valid_q <= 1'b0;
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_open) begin
			out_q <= skid_valid_q ? skid_q : new_res;
		end else if (new_valid) begin
			skid_q <= new_res;
		end
	end

	assign out_valid          = out_valid_q;
	assign result_kind        = out_q.kind;
	assign tbl_id             = out_q.tbl_id;
	assign syntax_indicator   = out_q.syntax_indicator;
	assign sect_len           = out_q.sect_len;
	assign stream_id          = out_q.stream_id;
	assign version            = out_q.version;
	assign current_next       = out_q.current_next;
	assign section_index      = out_q.section_index;
	assign last_section_index = out_q.last_section_index;
	assign entry_total        = out_q.entry_total;
	assign prog_num           = out_q.prog_num;
	assign pid                = out_q.pid;

`ifndef ASSERT_OFF
	a_skid_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !new_valid)
		else $error("result produced while the skid register is occupied");

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CNT_W'(MAX_ENTRIES))
		else $error("stored entry count exceeds table size");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LK_SCAN) |-> (stored_q != '0))
		else $error("lookup walk running on an empty table");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> (CNT_W'(addr_q) < stored_q))
		else $error("lookup reads beyond the stored entries");

	a_done_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		lk_done |=> (state_q == LK_IDLE) && !chk_s1)
		else $error("lookup walk did not stop after its answer");
`endif

endmodule
